[hw/rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: payload structs, command codes,
// and the descriptor passed from the front end to the back end.
package rau_pkg;

    localparam int CMD_W = 3;
    localparam int MAG_W = 63;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4,
        CMD_BAD5 = 3'd5,
        CMD_BAD6 = 3'd6,
        CMD_BAD7 = 3'd7
    } cmd_t;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         order;
        logic               error;
    } out_item_t;

    // Classified job: magnitudes to reduce plus flags.
    typedef struct packed {
        logic              reduce;   // run gcd/divide
        logic              neg;      // result sign
        logic [MAG_W-1:0]  num_mag;
        logic [MAG_W-1:0]  den_mag;
        logic [1:0]        order;
        logic              error;
    } job_t;

endpackage

[hw/rtl/rational_arith_unit.sv]
// Rational arithmetic unit: add/sub/mul/div/compare of two fractions, result
// reduced to lowest terms. The front end forms cross products, then the back end
// runs a binary gcd plus two 63-step divisions on one shared subtract-shift
// unit; compare, error and 0/x items skip the gcd and divisions there.
// Throughput is set by the back end, which serves one job at a time. Reset is
// asynchronous, low active, and empties the job queue and result register.
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    // front -> queue
    logic f_valid, f_ready;
    job_t f_job;
    // queue -> back
    logic b_valid, b_ready;
    job_t b_job;

    rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    rau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_job)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

[hw/rtl/rau_front.sv]
// Front end: widens operands, forms cross products, classifies the command
// and pushes a job descriptor. Uses rau_pkg.
module rau_front
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_CLS, S_OUT} state_t;

    localparam int OB = OPERAND_BITS;

    state_t state_reg;
    logic [2:0] cmd_reg;
    logic an_neg_reg, bn_neg_reg, bad_reg;
    logic [OB-1:0] an_reg, bn_reg;
    logic [OB-2:0] ad_reg, bd_reg;
    logic [MAG_W-1:0] p1_reg, p2_reg, pn_reg, pd_reg; // an*bd, ad*bn, an*bn, ad*bd
    logic p1n_reg, p2n_reg, pnn_reg;
    logic [MAG_W-1:0] sum_reg;
    logic sumn_reg;
    logic [1:0] ord_reg;
    job_t job_reg;

    logic [OB-1:0] an_raw, bn_raw, an_m, bn_m;
    logic an_s, bn_s;
    logic [MAG_W-1:0] sa, sb;
    logic sa_n, sb_n;

    always_comb
    begin
        an_raw = in_item.a_num[OB-1:0];
        bn_raw = in_item.b_num[OB-1:0];
        an_s = an_raw[OB-1];
        bn_s = bn_raw[OB-1];
        an_m = an_s ? (~an_raw + 1'b1) : an_raw;
        bn_m = bn_s ? (~bn_raw + 1'b1) : bn_raw;
    end

    // Signed add of p1 and +/-p2.
    always_comb
    begin
        sa_n = p1n_reg;
        sb_n = (cmd_reg == CMD_SUB) ? ((p2_reg != '0) && !p2n_reg) : p2n_reg;
        sa = p1_reg;
        sb = p2_reg;
    end

    assign full      = (state_reg != S_IDLE);
    assign job_valid = (state_reg == S_OUT);
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (push)
                    begin
                        cmd_reg    <= in_item.cmd;
                        an_reg     <= an_m;
                        bn_reg     <= bn_m;
                        an_neg_reg <= an_s;
                        bn_neg_reg <= bn_s;
                        ad_reg     <= in_item.a_den[OB-2:0];
                        bd_reg     <= in_item.b_den[OB-2:0];
                        bad_reg    <= (in_item.a_den[OB-2:0] == '0) ||
                                      (in_item.b_den[OB-2:0] == '0);
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    p1_reg  <= MAG_W'({1'b0, an_reg} * {2'b0, bd_reg});
                    p2_reg  <= MAG_W'({2'b0, ad_reg} * {1'b0, bn_reg});
                    pn_reg  <= MAG_W'({1'b0, an_reg} * {1'b0, bn_reg});
                    pd_reg  <= MAG_W'({2'b0, ad_reg} * {2'b0, bd_reg});
                    p1n_reg <= an_neg_reg && (an_reg != '0);
                    p2n_reg <= bn_neg_reg && (bn_reg != '0);
                    pnn_reg <= (an_neg_reg != bn_neg_reg) && (an_reg != '0) &&
                               (bn_reg != '0);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (sa_n == sb_n)
                    begin
                        sum_reg  <= sa + sb;
                        sumn_reg <= sa_n;
                    end
                    else if (sa >= sb)
                    begin
                        sum_reg  <= sa - sb;
                        sumn_reg <= sa_n;
                    end
                    else
                    begin
                        sum_reg  <= sb - sa;
                        sumn_reg <= sb_n;
                    end
                    // order a vs b from p1 (signed) vs p2 (signed)
                    if (p1n_reg != p2n_reg)
                        ord_reg <= p1n_reg ? ORD_LT : ORD_GT;
                    else if (p1_reg == p2_reg)
                        ord_reg <= ORD_EQ;
                    else if ((p1_reg > p2_reg) != p1n_reg)
                        ord_reg <= ORD_GT;
                    else
                        ord_reg <= ORD_LT;
                    state_reg <= S_CLS;
                end
                S_CLS:
                begin
                    // compare, error and unknown commands carry 0/0
                    job_reg.order  <= ord_reg;
                    job_reg.reduce <= 1'b0;
                    job_reg.error  <= 1'b0;
                    job_reg.neg    <= 1'b0;
                    job_reg.num_mag <= '0;
                    job_reg.den_mag <= '0;
                    if (bad_reg)
                    begin
                        job_reg.order <= ORD_EQ;
                        job_reg.error <= 1'b1;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_ADD, CMD_SUB:
                            begin
                                job_reg.reduce  <= 1'b1;
                                job_reg.num_mag <= sum_reg;
                                job_reg.den_mag <= pd_reg;
                                job_reg.neg     <= sumn_reg && (sum_reg != '0);
                            end
                            CMD_MUL:
                            begin
                                job_reg.reduce  <= 1'b1;
                                job_reg.num_mag <= pn_reg;
                                job_reg.den_mag <= pd_reg;
                                job_reg.neg     <= pnn_reg;
                            end
                            CMD_DIV:
                            begin
                                job_reg.neg <= (p1n_reg != p2n_reg) && (p1_reg != '0);
                                if (p2_reg == '0)
                                    job_reg.error <= 1'b1;
                                else
                                begin
                                    job_reg.reduce  <= 1'b1;
                                    job_reg.num_mag <= p1_reg;
                                    job_reg.den_mag <= p2_reg;
                                end
                            end
                            CMD_CMP: ;
                            default: job_reg.error <= 1'b1;
                        endcase
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (job_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/rau_queue.sv]
// Two-entry job queue between front and back ends. Uses rau_pkg.
module rau_queue
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

[hw/rtl/rau_back.sv]
// Back end: binary gcd then two restoring divisions on a shared
// subtract-shift unit; holds the result in an output register. Uses rau_pkg.
module rau_back
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    typedef enum logic [2:0] {S_IDLE, S_TWOS, S_ODDA, S_LOOP, S_DIVN, S_DIVD, S_DONE}
        state_t;

    localparam int CW = $clog2(MAG_W + 1);

    state_t state_reg;
    job_t job_reg;
    logic [MAG_W-1:0] ga_reg, gb_reg, g_reg;
    logic [CW-1:0] sh_reg;
    logic [CW-1:0] bit_reg;
    logic [MAG_W-1:0] q_reg, r_reg, qn_reg;
    out_item_t res_reg;
    logic res_full_reg;

    logic [MAG_W-1:0] dvd, rsh, rtry;
    logic take;

    assign dvd  = (state_reg == S_DIVN) ? job_reg.num_mag : job_reg.den_mag;
    assign rsh  = {r_reg[MAG_W-2:0], dvd[bit_reg[CW-1:0]]};
    assign take = ({r_reg[MAG_W-1], rsh} >= {1'b0, g_reg});
    assign rtry = rsh - g_reg;

    assign job_ready = (state_reg == S_IDLE);
    assign empty     = !res_full_reg;
    assign out_item  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            res_full_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_full_reg)
                res_full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        ga_reg  <= job.num_mag;
                        gb_reg  <= job.den_mag;
                        sh_reg  <= '0;
                        state_reg <= job.reduce ? S_TWOS : S_DONE;
                        if (job.reduce && job.num_mag == '0)
                        begin
                            // 0/x reduces to 0/1
                            job_reg.den_mag <= MAG_W'(1);
                            job_reg.reduce  <= 1'b0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_TWOS:
                begin
                    if (((ga_reg | gb_reg) & MAG_W'(1)) == '0)
                    begin
                        ga_reg <= ga_reg >> 1;
                        gb_reg <= gb_reg >> 1;
                        sh_reg <= sh_reg + 1'b1;
                    end
                    else
                        state_reg <= S_ODDA;
                end
                S_ODDA:
                begin
                    if (!ga_reg[0])
                        ga_reg <= ga_reg >> 1;
                    else
                        state_reg <= S_LOOP;
                end
                S_LOOP:
                begin
                    if (gb_reg == '0)
                    begin
                        g_reg   <= ga_reg << sh_reg;
                        r_reg   <= '0;
                        bit_reg <= CW'(MAG_W - 1);
                        state_reg <= S_DIVN;
                    end
                    else if (!gb_reg[0])
                        gb_reg <= gb_reg >> 1;
                    else if (ga_reg > gb_reg)
                    begin
                        ga_reg <= gb_reg;
                        gb_reg <= ga_reg - gb_reg;
                    end
                    else
                        gb_reg <= gb_reg - ga_reg;
                end
                S_DIVN, S_DIVD:
                begin
                    r_reg <= take ? rtry : rsh;
                    q_reg <= {q_reg[MAG_W-2:0], take};
                    if (bit_reg == '0)
                    begin
                        if (state_reg == S_DIVN)
                        begin
                            qn_reg  <= {q_reg[MAG_W-2:0], take};
                            r_reg   <= '0;
                            bit_reg <= CW'(MAG_W - 1);
                            state_reg <= S_DIVD;
                        end
                        else
                        begin
                            job_reg.num_mag <= qn_reg;
                            job_reg.den_mag <= {q_reg[MAG_W-2:0], take};
                            state_reg <= S_DONE;
                        end
                    end
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                S_DONE:
                begin
                    if (!res_full_reg || pop)
                    begin
                        res_reg.res_num <= job_reg.neg ? -$signed({1'b0, job_reg.num_mag})
                                                       : $signed({1'b0, job_reg.num_mag});
                        res_reg.res_den <= job_reg.error ? '0 : job_reg.den_mag;
                        res_reg.order   <= job_reg.order;
                        res_reg.error   <= job_reg.error;
                        res_full_reg    <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
